[rtl/huffman_symbol_encoder_bit_packer_core_macros.svh]
// assertion macros for the encoder/packer rtl, used by hsebp_back
// expects a clock named clk and a reset named rst in the module that uses them
`ifndef HUFFMAN_SYMBOL_ENCODER_BIT_PACKER_CORE_MACROS_SVH
`define HUFFMAN_SYMBOL_ENCODER_BIT_PACKER_CORE_MACROS_SVH

// checked only out of reset
`define HSEBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define HSEBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/hsebp_pkg.sv]
// shared types and constants for the huffman encoder / bit packer
// no dependencies
package hsebp_pkg;

  localparam int BYTE_BITS = 8;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

endpackage

[rtl/hsebp_queue.sv]
// two-entry command queue between front and back
// depends on hsebp_pkg (nothing used beyond the import convention)
module hsebp_queue
  import hsebp_pkg::*;
#(
  parameter int DATA_W = 39
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [DATA_W-1:0] wr_data,
  output logic              q_full,
  input  logic              rd_en,
  output logic [DATA_W-1:0] rd_data,
  output logic              q_empty
);

  logic [DATA_W-1:0] slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;

  assign q_full  = (fill == 2'd2);
  assign q_empty = (fill == 2'd0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[rtl/hsebp_front.sv]
// front end: takes items, owns the code table, classifies and forwards commands
// depends on hsebp_pkg
module hsebp_front
  import hsebp_pkg::*;
#(
  parameter int SYMBOL_COUNT  = 256,
  parameter int MAX_CODE_BITS = 32,
  localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1,
  localparam int LEN_W = $clog2(MAX_CODE_BITS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [1:0]               operation,
  input  logic [7:0]               symbol,
  input  logic [31:0]              code_value,
  input  logic [5:0]               code_len,
  output logic                     cmd_valid,
  input  logic                     cmd_full,
  output logic                     cmd_flush,
  output logic [MAX_CODE_BITS-1:0] cmd_code,
  output logic [LEN_W-1:0]         cmd_len
);

  logic [MAX_CODE_BITS+LEN_W-1:0] table_mem [SYMBOL_COUNT];
  logic [MAX_CODE_BITS+LEN_W-1:0] rd_entry;
  logic                           stage_valid;
  logic                           stage_flush;
  logic                           accept;
  logic                           sym_ok;
  logic [IDX_W-1:0]               idx;
  logic [LEN_W-1:0]               len_sat;
  logic                           do_write;
  logic                           do_read;
  logic                           fwd;

  assign full   = stage_valid && cmd_full;
  assign accept = push && !full;
  assign sym_ok = ({1'b0, symbol} < 9'(SYMBOL_COUNT));
  assign idx    = symbol[IDX_W-1:0];
  assign len_sat = (code_len > 6'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS)
                                                  : code_len[LEN_W-1:0];

  // classify the item
  always_comb begin
    do_write = 1'b0;
    do_read  = 1'b0;
    fwd      = 1'b0;
    case (op_t'(operation))
      OP_LOAD: begin
        do_write = accept && sym_ok;
      end
      OP_ENCODE: begin
        do_read = accept && sym_ok;
        fwd     = accept && sym_ok;
      end
      OP_FLUSH: begin
        fwd = accept;
      end
      default: begin
        fwd = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      table_mem[idx] <= {code_value[MAX_CODE_BITS-1:0], len_sat};
    end
    if (do_read) begin
      rd_entry <= table_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      stage_flush <= 1'b0;
    end else if (!full) begin
      stage_valid <= fwd;
      stage_flush <= (op_t'(operation) == OP_FLUSH);
    end
  end

  assign cmd_valid = stage_valid && !cmd_full;
  assign cmd_flush = stage_flush;
  assign cmd_code  = rd_entry[MAX_CODE_BITS+LEN_W-1:LEN_W];
  assign cmd_len   = rd_entry[LEN_W-1:0];

endmodule

[rtl/hsebp_back.sv]
// back end: bit packer that appends codes msb first and drains whole bytes,
// then pads a partial one on flush; uses hsebp_pkg and the assertion macros
`include "huffman_symbol_encoder_bit_packer_core_macros.svh"

module hsebp_back
  import hsebp_pkg::*;
#(
  parameter int MAX_CODE_BITS = 32,
  localparam int LEN_W = $clog2(MAX_CODE_BITS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_empty,
  output logic                     q_pop,
  input  logic                     cmd_flush,
  input  logic [MAX_CODE_BITS-1:0] cmd_code,
  input  logic [LEN_W-1:0]         cmd_len,
  output logic                     empty,
  input  logic                     pop,
  output logic [7:0]               out_byte,
  output logic                     last_of_run
);

  localparam int W     = MAX_CODE_BITS + BYTE_BITS;
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]             word;
  logic [W-1:0]             word_next;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         cnt_next;
  logic                     o_valid;
  logic                     can_emit;
  logic                     emit;
  logic                     emit_last;
  logic [LEN_W-1:0]         sh;
  logic [MAX_CODE_BITS-1:0] code_al;
  logic [W-1:0]             code_part;
  logic [W-1:0]             pend_part;

  assign can_emit = !o_valid || pop;
  assign empty    = !o_valid;

  // left-align the code, then slide it in right behind the pending bits
  assign sh        = LEN_W'(MAX_CODE_BITS) - cmd_len;
  assign code_al   = cmd_code << sh;
  assign code_part = {code_al, {BYTE_BITS{1'b0}}} >> cnt[2:0];
  assign pend_part = {word[W-1 -: BYTE_BITS], {MAX_CODE_BITS{1'b0}}};

  always_comb begin
    word_next = word;
    cnt_next  = cnt;
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    if (cnt >= CNT_W'(BYTE_BITS)) begin
      if (can_emit) begin
        emit      = 1'b1;
        emit_last = (cnt < CNT_W'(2 * BYTE_BITS));
        word_next = word << BYTE_BITS;
        cnt_next  = cnt - CNT_W'(BYTE_BITS);
      end
    end else if (!q_empty) begin
      if (cmd_flush) begin
        if (cnt == '0) begin
          q_pop = 1'b1;
        end else if (can_emit) begin
          q_pop     = 1'b1;
          emit      = 1'b1;
          emit_last = 1'b1;
          word_next = '0;
          cnt_next  = '0;
        end
      end else begin
        q_pop     = 1'b1;
        word_next = pend_part | code_part;
        cnt_next  = cnt + CNT_W'(cmd_len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word    <= '0;
      cnt     <= '0;
      o_valid <= 1'b0;
    end else begin
      word <= word_next;
      cnt  <= cnt_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (pop) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= word[W-1 -: BYTE_BITS];
      last_of_run <= emit_last;
    end
  end

  `HSEBP_ASSERT(a_cnt_bound, cnt <= CNT_W'(W - 1), "bit count past packer width")
  `HSEBP_ASSERT(a_no_pop_drain, (cnt >= CNT_W'(BYTE_BITS)) |-> !q_pop, "command taken while draining")
  `HSEBP_ASSERT_ALWAYS(a_rst_clear, rst |=> (cnt == '0) && !o_valid, "packer not cleared by reset")

endmodule

[rtl/huffman_symbol_encoder_bit_packer_core.sv]
// top level of the huffman symbol encoder with msb-first bit packer
// depends on hsebp_pkg, hsebp_front, hsebp_queue, hsebp_back
//
// channel   direction  handshake                 payload
// input     in         push / full               operation, symbol, code_value, code_len
// result    out        empty / pop               out_byte, last_of_run
//
// the front takes one item per cycle while its stage is empty or the two-entry queue has room
// loads write the code table and never reach the back
// an encode is merged by the back, which drains each finished byte before the next
// command; a flush pads any partial byte; the single back packer sets the sustained rate
// rst is synchronous, clears control state; the code table is unset until loaded
// a stalled pop holds the result register, then the back, queue and front back up in turn
module huffman_symbol_encoder_bit_packer_core
  import hsebp_pkg::*;
#(
  parameter int SYMBOL_COUNT  = 256,
  parameter int MAX_CODE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation,
  input  logic [7:0]  symbol,
  input  logic [31:0] code_value,
  input  logic [5:0]  code_len,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last_of_run
);

  localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);
  // queue entry: flush flag, code, length
  localparam int CMD_W = 1 + MAX_CODE_BITS + LEN_W;

  logic                     f_valid;
  logic                     f_flush;
  logic [MAX_CODE_BITS-1:0] f_code;
  logic [LEN_W-1:0]         f_len;
  logic                     q_full;
  logic                     q_empty;
  logic                     q_pop;
  logic [CMD_W-1:0]         q_data;

  // front: classification and code table lookup
  hsebp_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .symbol     (symbol),
    .code_value (code_value),
    .code_len   (code_len),
    .cmd_valid  (f_valid),
    .cmd_full   (q_full),
    .cmd_flush  (f_flush),
    .cmd_code   (f_code),
    .cmd_len    (f_len)
  );

  // short queue so front and back stall on their own
  hsebp_queue #(
    .DATA_W(CMD_W)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (f_valid),
    .wr_data({f_flush, f_code, f_len}),
    .q_full (q_full),
    .rd_en  (q_pop),
    .rd_data(q_data),
    .q_empty(q_empty)
  );

  // back: bit packer and result register
  hsebp_back #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .cmd_flush  (q_data[CMD_W-1]),
    .cmd_code   (q_data[CMD_W-2 -: MAX_CODE_BITS]),
    .cmd_len    (q_data[LEN_W-1:0]),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .last_of_run(last_of_run)
  );

endmodule

[bench/huffman_symbol_encoder_bit_packer_core_tb.sv]
// self-checking bench for huffman_symbol_encoder_bit_packer_core
// holds its own table/packer predictor in a small scoreboard class
// depends on hsebp_pkg and the core rtl
`timescale 1ns / 100ps

module huffman_symbol_encoder_bit_packer_core_tb;
  import hsebp_pkg::*;

  localparam int SYMBOLS     = 256;
  localparam int CODE_BITS   = 32;
  localparam logic [1:0] OP_UNUSED = 2'd3;   // reserved code, ignored by the core
  localparam int RANDOM_ITEMS = 415;
  localparam int DRAIN_CYCLES = 20;
  // worst case per item: an input gap, the back end work and a pop stall on each of its bytes
  localparam int CYCLE_LIMIT = 200000;

  // expected byte stream of the packer, built from every accepted transaction
  class huffman_byte_tracker;
    logic [31:0] code_tbl [SYMBOLS];
    logic [5:0]  len_tbl  [SYMBOLS];
    bit          loaded   [SYMBOLS];
    logic [7:0]  acc_bits;
    int          acc_count;
    logic [8:0]  expected_bytes [$];   // {last_of_run, out_byte}
    int          mismatches;

    function new();
      acc_bits   = '0;
      acc_count  = 0;
      mismatches = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function void note_item(logic [1:0] op, logic [7:0] sym, logic [31:0] val,
                            logic [5:0] len);
      int         first;
      int         clen;
      logic [7:0] padded;
      logic [8:0] tail;
      first = expected_bytes.size();
      case (op)
        OP_LOAD: begin
          code_tbl[sym] = val;
          len_tbl[sym]  = (len > CODE_BITS) ? 6'(CODE_BITS) : len;
          loaded[sym]   = 1'b1;
        end
        OP_ENCODE: begin
          clen = len_tbl[sym];
          // msb of the code goes out first
          for (int i = clen - 1; i >= 0; i--) begin
            acc_bits = {acc_bits[6:0], code_tbl[sym][i]};
            acc_count++;
            if (acc_count == BYTE_BITS) begin
              expected_bytes.push_back({1'b0, acc_bits});
              acc_bits  = '0;
              acc_count = 0;
            end
          end
        end
        OP_FLUSH: begin
          if (acc_count > 0) begin
            padded = acc_bits << (BYTE_BITS - acc_count);
            expected_bytes.push_back({1'b0, padded});
            acc_bits  = '0;
            acc_count = 0;
          end
        end
        default: ;
      endcase
      // final byte caused by this transaction carries the run mark
      if (expected_bytes.size() > first) begin
        tail = expected_bytes.pop_back();
        tail[8] = 1'b1;
        expected_bytes.push_back(tail);
      end
    endfunction

    function void check_byte(logic [7:0] got_byte, logic got_last);
      logic [8:0] exp;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output byte %h (last_of_run %b)", got_byte, got_last);
        mismatches++;
        return;
      end
      exp = expected_bytes.pop_front();
      if (got_byte !== exp[7:0]) begin
        $error("out_byte: expected %h, got %h", exp[7:0], got_byte);
        mismatches++;
      end
      if (got_last !== exp[8]) begin
        $error("last_of_run: expected %b, got %b", exp[8], got_last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  operation = OP_LOAD;
  logic [7:0]  symbol = '0;
  logic [31:0] code_value = '0;
  logic [5:0]  code_len = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        last_of_run;

  huffman_byte_tracker tracker = new();
  logic [7:0]  loaded_syms [$];   // symbols that are safe to encode
  bit          push_burst = 1'b0; // no idle gaps on the input side while set
  bit          pop_burst  = 1'b0; // no stalls on the result side while set
  int          cycles = 0;

  huffman_symbol_encoder_bit_packer_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .operation   (operation),
    .symbol      (symbol),
    .code_value  (code_value),
    .code_len    (code_len),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  always #5 clk = ~clk;

  // hard stop in case the core hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one input transaction: optional idle gap, then hold push until accepted
  task automatic send_item(logic [1:0] op, logic [7:0] sym, logic [31:0] val,
                           logic [5:0] len);
    int gap;
    gap = push_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    operation   <= op;
    symbol      <= sym;
    code_value  <= val;
    code_len    <= len;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    tracker.note_item(op, sym, val, len);
    if (op == OP_LOAD && !loaded_syms.size()) loaded_syms.push_back(sym);
    else if (op == OP_LOAD && !(sym inside {loaded_syms})) loaded_syms.push_back(sym);
    if ($urandom_range(0, 39) == 0) push_burst = !push_burst;
  endtask

  // mostly well-formed traffic: loads, encodes of loaded symbols, flushes,
  // plus a little of the reserved operation code
  task automatic run_random(int count);
    int          done;
    int          r;
    int          k;
    logic [7:0]  sym;
    logic [5:0]  len;
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 99);
      if (r < 18 || loaded_syms.size() == 0) begin
        sym = 8'($urandom_range(0, SYMBOLS - 1));
        k = $urandom_range(0, 19);
        // short codes dominate, with zero, saturating and full-width lengths mixed in
        if (k == 0)      len = 6'd0;
        else if (k == 1) len = 6'($urandom_range(CODE_BITS + 1, 63));
        else if (k == 2) len = 6'(CODE_BITS);
        else if (k < 14) len = 6'($urandom_range(1, 12));
        else             len = 6'($urandom_range(1, CODE_BITS));
        send_item(OP_LOAD, sym, $urandom, len);
        done++;
      end else if (r < 80) begin
        sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        send_item(OP_ENCODE, sym, $urandom, 6'($urandom_range(0, 63)));
        done++;
      end else if (r < 95) begin
        send_item(OP_FLUSH, 8'($urandom_range(0, 255)), $urandom,
                  6'($urandom_range(0, 63)));
        done++;
      end else begin
        // ignored by the core, not counted
        send_item(OP_UNUSED, 8'($urandom_range(0, 255)), $urandom,
                  6'($urandom_range(0, 63)));
      end
    end
  endtask

  // result side: random stalls on pop, check every accepted byte
  initial begin
    int stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      stall = pop_burst ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty !== 1'b0) @(posedge clk);
      tracker.check_byte(out_byte, last_of_run);
      if ($urandom_range(0, 39) == 0) pop_burst = !pop_burst;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part: field extremes, every operation and the corner cases
    send_item(OP_LOAD,   8'd0,   32'hFFFF_FFFF, 6'd32);  // full-width code
    send_item(OP_LOAD,   8'd255, 32'h0000_0000, 6'd1);
    send_item(OP_LOAD,   8'd1,   32'h0000_00A5, 6'd0);   // zero length
    send_item(OP_LOAD,   8'd2,   32'h1234_5678, 6'd63);  // length saturates
    send_item(OP_LOAD,   8'd3,   32'hFFFF_FFF5, 6'd3);   // wide value, low bits only
    send_item(OP_LOAD,   8'd4,   32'h0000_007F, 6'd7);
    send_item(OP_FLUSH,  8'd0,   32'h0,         6'd0);   // nothing pending
    send_item(OP_ENCODE, 8'd0,   32'h0,         6'd0);   // four whole bytes
    send_item(OP_ENCODE, 8'd255, 32'hFFFF_FFFF, 6'd63);  // one bit pending
    send_item(OP_ENCODE, 8'd0,   32'h0,         6'd0);   // straddles bytes
    send_item(OP_ENCODE, 8'd1,   32'h0,         6'd0);   // no output
    send_item(OP_ENCODE, 8'd2,   32'h0,         6'd0);
    send_item(OP_UNUSED, 8'd255, 32'hFFFF_FFFF, 6'd63);  // reserved code
    send_item(OP_ENCODE, 8'd3,   32'h0,         6'd0);
    send_item(OP_FLUSH,  8'd255, 32'hFFFF_FFFF, 6'd63);  // padded byte
    send_item(OP_FLUSH,  8'd0,   32'h0,         6'd0);   // already empty
    send_item(OP_ENCODE, 8'd4,   32'h0,         6'd0);   // seven pending
    send_item(OP_ENCODE, 8'd255, 32'h0,         6'd0);   // completes exactly one byte
    send_item(OP_ENCODE, 8'd4,   32'h0,         6'd0);
    send_item(OP_ENCODE, 8'd0,   32'h0,         6'd0);   // longest run of bytes
    send_item(OP_LOAD,   8'd0,   32'h8000_0001, 6'd32);  // overwrite a used entry
    send_item(OP_ENCODE, 8'd0,   32'h0,         6'd0);
    send_item(OP_UNUSED, 8'd0,   32'h0,         6'd0);
    send_item(OP_FLUSH,  8'd0,   32'h0,         6'd0);

    run_random(RANDOM_ITEMS);
    push <= 1'b0;

    // drain, then give the core time to show any stray byte
    while (tracker.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.expected_bytes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[huffman_symbol_encoder_bit_packer_core.f]
+incdir+rtl
rtl/hsebp_pkg.sv
rtl/hsebp_queue.sv
rtl/hsebp_front.sv
rtl/hsebp_back.sv
rtl/huffman_symbol_encoder_bit_packer_core.sv
bench/huffman_symbol_encoder_bit_packer_core_tb.sv
